### rtl/v4nl_pkg.sv
// ----------------------------------------------------------------------------
// v4nl_pkg
// Shared widths, command codes and sideband types of the vector4 unit.
// ----------------------------------------------------------------------------
`default_nettype none

package v4nl_pkg;

  localparam int FIELD_W   = 24;             // Q8.16 component
  localparam int FRAC_BITS = 16;
  localparam int SCALAR_W  = 34;
  localparam int OP_W      = FIELD_W + 1;    // room for a - b
  localparam int PROD_W    = 2 * OP_W;
  localparam int SUM_W     = PROD_W + 2;     // sum of four products
  localparam int ROOT_W    = 26;
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int MAG_W     = FIELD_W;
  localparam int DQ_W      = FRAC_BITS + 1;  // quotient never exceeds one
  localparam int SQ_PER    = 2;              // root iterations per stage

  localparam logic signed [SCALAR_W-1:0] SCALAR_MAX = SCALAR_W'(64'sd1 <<< 32);
  localparam logic signed [SCALAR_W-1:0] SCALAR_MIN = -SCALAR_MAX;
  localparam logic [DQ_W-1:0]            ONE_Q      = DQ_W'(1) << FRAC_BITS;

  typedef enum logic [2:0] {
    CMD_NORM_ZERO = 3'd0,
    CMD_NORM_KEEP = 3'd1,
    CMD_LEN       = 3'd2,
    CMD_SQLEN     = 3'd3,
    CMD_DOT       = 3'd4,
    CMD_DIST      = 3'd5
  } cmd_e;

  typedef logic [3:0][FIELD_W-1:0] vec_t;
  typedef logic [3:0][MAG_W-1:0]   mag_t;
  typedef logic [3:0][DQ_W-1:0]    quo_t;

  // carried alongside the root pipeline
  typedef struct packed {
    logic [2:0]                  cmd;
    vec_t                        a;
    logic                        zl;
    logic signed [SCALAR_W-1:0]  scalar;
  } side_t;

  // carried alongside the divider
  typedef struct packed {
    logic [2:0]                  cmd;
    logic [3:0]                  neg;
    logic                        zl;
    logic signed [SCALAR_W-1:0]  scalar;
  } meta_t;

endpackage

`default_nettype wire

### rtl/v4nl_dot.sv
// ----------------------------------------------------------------------------
// v4nl_dot
// Three-stage front end: operand select, four multipliers, sum of products.
// ----------------------------------------------------------------------------
`default_nettype none

module v4nl_dot (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  input  wire logic [2:0]       cmd_i,
  input  wire v4nl_pkg::vec_t   a_i,
  input  wire v4nl_pkg::vec_t   b_i,
  output logic                  valid_o,
  output logic [v4nl_pkg::RAD_W-1:0] rad_o,
  output v4nl_pkg::side_t       side_o
);
  import v4nl_pkg::*;

  // stage A: input register
  logic       va_q;
  logic [2:0] cmd_a_q;
  vec_t       a_a_q, b_a_q;

  // stage B: products
  logic                            vb_q;
  logic [2:0]                      cmd_b_q;
  vec_t                            a_b_q;
  logic [3:0][PROD_W-1:0]          prod_b_q;
  logic [3:0][PROD_W-1:0]          prod_d;

  // stage C: sum
  logic                            vc_q;
  logic signed [SUM_W-1:0]         sum_c_q;
  side_t                           side_c_q;
  logic signed [SUM_W-1:0]         sum_d;
  logic signed [SUM_W-1:0]         sh_d;
  logic signed [SCALAR_W-1:0]      pre_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_comb begin
    logic signed [OP_W-1:0] u, v, ea, eb;
    for (int i = 0; i < 4; i++) begin
      ea = OP_W'($signed(a_a_q[i]));
      eb = OP_W'($signed(b_a_q[i]));
      if (cmd_a_q == CMD_DOT) begin
        u = ea;
        v = eb;
      end else if (cmd_a_q == CMD_DIST) begin
        u = ea - eb;
        v = ea - eb;
      end else begin
        u = ea;
        v = ea;
      end
      // operands widened first so the full product is kept
      prod_d[i] = PROD_W'(PROD_W'(u) * PROD_W'(v));
    end
  end

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < 4; i++) begin
      sum_d = sum_d + SUM_W'($signed(prod_b_q[i]));
    end
    sh_d = sum_d >>> FRAC_BITS;
    if (sh_d > SUM_W'(SCALAR_MAX)) begin
      pre_d = SCALAR_MAX;
    end else if (sh_d < SUM_W'(SCALAR_MIN)) begin
      pre_d = SCALAR_MIN;
    end else begin
      pre_d = SCALAR_W'(sh_d);
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_a_q         <= cmd_i;
    a_a_q           <= a_i;
    b_a_q           <= b_i;
    cmd_b_q         <= cmd_a_q;
    a_b_q           <= a_a_q;
    prod_b_q        <= prod_d;
    sum_c_q         <= sum_d;
    side_c_q.cmd    <= cmd_b_q;
    side_c_q.a      <= a_b_q;
    side_c_q.zl     <= (a_b_q == '0);
    side_c_q.scalar <= pre_d;
  end

  assign valid_o = vc_q;
  assign rad_o   = RAD_W'(sum_c_q);
  assign side_o  = side_c_q;

endmodule

`default_nettype wire

### rtl/v4nl_sqrt.sv
// ----------------------------------------------------------------------------
// v4nl_sqrt
// Pipelined restoring integer square root, two result bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module v4nl_sqrt (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  input  wire logic [v4nl_pkg::RAD_W-1:0]  rad_i,
  input  wire v4nl_pkg::side_t             side_i,
  output logic                             valid_o,
  output logic [v4nl_pkg::ROOT_W-1:0]      root_o,
  output v4nl_pkg::side_t                  side_o
);
  import v4nl_pkg::*;

  localparam int NST = ROOT_W / SQ_PER;
  localparam int RW  = ROOT_W + 2;

  logic              vld_q  [NST];
  logic [RW-1:0]     rem_q  [NST];
  logic [ROOT_W-1:0] root_q [NST];
  logic [RAD_W-1:0]  rad_q  [NST];
  side_t             side_q [NST];

  for (genvar st = 0; st < NST; st++) begin : g_st
    logic              v_p;
    logic [RW-1:0]     rem_p, rem_n;
    logic [ROOT_W-1:0] root_p, root_n;
    logic [RAD_W-1:0]  rad_p, rad_n;
    side_t             side_p;

    if (st == 0) begin : g_src
      assign v_p    = valid_i;
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = rad_i;
      assign side_p = side_i;
    end else begin : g_src
      assign v_p    = vld_q[st-1];
      assign rem_p  = rem_q[st-1];
      assign root_p = root_q[st-1];
      assign rad_p  = rad_q[st-1];
      assign side_p = side_q[st-1];
    end

    always_comb begin
      logic [RW+1:0] acc, trial;
      rem_n  = rem_p;
      root_n = root_p;
      rad_n  = rad_p;
      for (int k = 0; k < SQ_PER; k++) begin
        acc   = {rem_n, rad_n[RAD_W-1 -: 2]};
        trial = {2'b00, root_n, 2'b01};
        if (acc >= trial) begin
          rem_n  = RW'(acc - trial);
          root_n = {root_n[ROOT_W-2:0], 1'b1};
        end else begin
          rem_n  = RW'(acc);
          root_n = {root_n[ROOT_W-2:0], 1'b0};
        end
        rad_n = {rad_n[RAD_W-3:0], 2'b00};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[st] <= 1'b0;
      end else begin
        vld_q[st] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[st]  <= rem_n;
      root_q[st] <= root_n;
      rad_q[st]  <= rad_n;
      side_q[st] <= side_p;
    end
  end

  assign valid_o = vld_q[NST-1];
  assign root_o  = root_q[NST-1];
  assign side_o  = side_q[NST-1];

endmodule

`default_nettype wire

### rtl/v4nl_div.sv
// ----------------------------------------------------------------------------
// v4nl_div
// Four-lane pipelined restoring divider, one quotient bit per stage.
// Computes (mag << FRAC_BITS) / len; the quotient is at most one.
// ----------------------------------------------------------------------------
`default_nettype none

module v4nl_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  input  wire v4nl_pkg::mag_t              mag_i,
  input  wire logic [v4nl_pkg::ROOT_W-1:0] len_i,
  input  wire v4nl_pkg::meta_t             meta_i,
  output logic                             valid_o,
  output v4nl_pkg::quo_t                   quo_o,
  output v4nl_pkg::meta_t                  meta_o
);
  import v4nl_pkg::*;

  localparam int NST = DQ_W;

  typedef logic [3:0][ROOT_W-1:0] rem_t;

  logic              vld_q  [NST];
  rem_t              rem_q  [NST];
  quo_t              quo_q  [NST];
  quo_t              dvd_q  [NST];
  logic [ROOT_W-1:0] len_q  [NST];
  meta_t             meta_q [NST];

  for (genvar st = 0; st < NST; st++) begin : g_st
    logic              v_p;
    rem_t              rem_p, rem_n;
    quo_t              quo_p, quo_n, dvd_p, dvd_n;
    logic [ROOT_W-1:0] len_p;
    meta_t             meta_p;

    if (st == 0) begin : g_src
      assign v_p    = valid_i;
      assign len_p  = len_i;
      assign meta_p = meta_i;
      assign quo_p  = '0;
      for (genvar l = 0; l < 4; l++) begin : g_lane
        assign rem_p[l] = ROOT_W'(mag_i[l] >> 1);
        assign dvd_p[l] = {mag_i[l][0], {FRAC_BITS{1'b0}}};
      end
    end else begin : g_src
      assign v_p    = vld_q[st-1];
      assign len_p  = len_q[st-1];
      assign meta_p = meta_q[st-1];
      assign quo_p  = quo_q[st-1];
      assign rem_p  = rem_q[st-1];
      assign dvd_p  = dvd_q[st-1];
    end

    always_comb begin
      logic [ROOT_W:0] acc;
      for (int l = 0; l < 4; l++) begin
        acc = {rem_p[l], dvd_p[l][DQ_W-1]};
        if (acc >= {1'b0, len_p}) begin
          rem_n[l] = ROOT_W'(acc - {1'b0, len_p});
          quo_n[l] = {quo_p[l][DQ_W-2:0], 1'b1};
        end else begin
          rem_n[l] = ROOT_W'(acc);
          quo_n[l] = {quo_p[l][DQ_W-2:0], 1'b0};
        end
        dvd_n[l] = {dvd_p[l][DQ_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[st] <= 1'b0;
      end else begin
        vld_q[st] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[st]  <= rem_n;
      quo_q[st]  <= quo_n;
      dvd_q[st]  <= dvd_n;
      len_q[st]  <= len_p;
      meta_q[st] <= meta_p;
    end
  end

  assign valid_o = vld_q[NST-1];
  assign quo_o   = quo_q[NST-1];
  assign meta_o  = meta_q[NST-1];

endmodule

`default_nettype wire

### rtl/vector4_normalize_length_unit_core.sv
// ----------------------------------------------------------------------------
// vector4_normalize_length_unit_core
// Four-component Q8.16 vector unit: normalize, length, squared length,
// dot product and distance, fully pipelined.
// ----------------------------------------------------------------------------
// Pipeline from start to done: 3 multiply/sum stages, 13 square root
//   stages, 17 divider stages and 1 output register.
// Throughput: one word per cycle; busy is never raised and the receiver
//   cannot stall, so the pipeline always advances.
// Reset: rst_ni clears only the valid bits; no word is in flight after it.
`default_nettype none

module vector4_normalize_length_unit_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [2:0]                          cmd_i,
  input  wire logic signed [v4nl_pkg::FIELD_W-1:0] a_x_i,
  input  wire logic signed [v4nl_pkg::FIELD_W-1:0] a_y_i,
  input  wire logic signed [v4nl_pkg::FIELD_W-1:0] a_z_i,
  input  wire logic signed [v4nl_pkg::FIELD_W-1:0] a_w_i,
  input  wire logic signed [v4nl_pkg::FIELD_W-1:0] b_x_i,
  input  wire logic signed [v4nl_pkg::FIELD_W-1:0] b_y_i,
  input  wire logic signed [v4nl_pkg::FIELD_W-1:0] b_z_i,
  input  wire logic signed [v4nl_pkg::FIELD_W-1:0] b_w_i,
  output logic                                     done_o,
  output logic signed [v4nl_pkg::FIELD_W-1:0]      out_x_o,
  output logic signed [v4nl_pkg::FIELD_W-1:0]      out_y_o,
  output logic signed [v4nl_pkg::FIELD_W-1:0]      out_z_o,
  output logic signed [v4nl_pkg::FIELD_W-1:0]      out_w_o,
  output logic signed [v4nl_pkg::SCALAR_W-1:0]     scalar_o,
  output logic                                     zero_length_o
);
  import v4nl_pkg::*;

  // Every stage advances every cycle, so the unit is always ready.
  assign busy = 1'b0;

  vec_t              a_vec, b_vec;
  logic              f_valid;
  logic [RAD_W-1:0]  f_rad;
  side_t             f_side;
  logic              s_valid;
  logic [ROOT_W-1:0] s_root;
  side_t             s_side;
  mag_t              s_mag;
  meta_t             s_meta;
  logic              d_valid;
  quo_t              d_quo;
  meta_t             d_meta;

  logic                        done_q;
  vec_t                        vec_q, vec_d;
  logic signed [SCALAR_W-1:0]  scalar_q;
  logic                        zl_q, zl_d;

  assign a_vec = {a_w_i, a_z_i, a_y_i, a_x_i};
  assign b_vec = {b_w_i, b_z_i, b_y_i, b_x_i};

  // products and their sum; squared length and dot finish here
  v4nl_dot u_dot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start),
    .cmd_i   (cmd_i),
    .a_i     (a_vec),
    .b_i     (b_vec),
    .valid_o (f_valid),
    .rad_o   (f_rad),
    .side_o  (f_side)
  );

  // floor(sqrt) of the sum of squares: length or distance
  v4nl_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_valid),
    .rad_i   (f_rad),
    .side_i  (f_side),
    .valid_o (s_valid),
    .root_o  (s_root),
    .side_o  (s_side)
  );

  // component magnitudes and the scalar result ahead of the divider
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      s_mag[i]      = s_side.a[i][FIELD_W-1] ? MAG_W'(-s_side.a[i]) : MAG_W'(s_side.a[i]);
      s_meta.neg[i] = s_side.a[i][FIELD_W-1];
    end
    s_meta.cmd = s_side.cmd;
    s_meta.zl  = s_side.zl;
    case (s_side.cmd)
      CMD_LEN, CMD_DIST:  s_meta.scalar = SCALAR_W'($signed({1'b0, s_root}));
      CMD_SQLEN, CMD_DOT: s_meta.scalar = s_side.scalar;
      default:            s_meta.scalar = '0;
    endcase
  end

  v4nl_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_valid),
    .mag_i   (s_mag),
    .len_i   (s_root),
    .meta_i  (s_meta),
    .valid_o (d_valid),
    .quo_o   (d_quo),
    .meta_o  (d_meta)
  );

  // saturate at one, restore the sign; zero vector on zero length or for non-normalize commands
  always_comb begin
    logic        norm;
    logic [DQ_W-1:0] q;
    norm = (d_meta.cmd == CMD_NORM_ZERO) || (d_meta.cmd == CMD_NORM_KEEP);
    zl_d = norm && d_meta.zl;
    for (int i = 0; i < 4; i++) begin
      q = (d_quo[i] > ONE_Q) ? ONE_Q : d_quo[i];
      if (norm && !d_meta.zl) begin
        vec_d[i] = d_meta.neg[i] ? -FIELD_W'(q) : FIELD_W'(q);
      end else begin
        vec_d[i] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    vec_q    <= vec_d;
    scalar_q <= d_meta.scalar;
    zl_q     <= zl_d;
  end

  assign done_o        = done_q;
  assign out_x_o       = vec_q[0];
  assign out_y_o       = vec_q[1];
  assign out_z_o       = vec_q[2];
  assign out_w_o       = vec_q[3];
  assign scalar_o      = scalar_q;
  assign zero_length_o = zl_q;

endmodule

`default_nettype wire
